[rtl/sipd_pkg.sv]
`timescale 1ns / 1ps
// Package for the SipHash-2-4 discriminator: key, lane init values and the
// command beat passed from the front end to the round engine. No dependencies.
package sipd_pkg;

    // Built-in 128-bit key, low and high words
    localparam logic [63:0] KEY_LO = 64'h794a1079ebc9d4b5;
    localparam logic [63:0] KEY_HI = 64'hd48187421b8bec6f;

    // SipHash init constants
    localparam logic [63:0] INIT_A = 64'h736f6d6570736575;
    localparam logic [63:0] INIT_B = 64'h646f72616e646f6d;
    localparam logic [63:0] INIT_C = 64'h6c7967656e657261;
    localparam logic [63:0] INIT_D = 64'h7465646279746573;

    // Lane values at the start of every message
    localparam logic [63:0] LANE_A_RST = INIT_A ^ KEY_LO;
    localparam logic [63:0] LANE_B_RST = INIT_B ^ KEY_HI;
    localparam logic [63:0] LANE_C_RST = INIT_C ^ KEY_LO;
    localparam logic [63:0] LANE_D_RST = INIT_D ^ KEY_HI;

    // Finalization marker xored into lane c
    localparam logic [63:0] FIN_XOR = 64'h00000000000000ff;

    // Command for the round engine:
    //   word  - message word to absorb (full word, or tail word with length)
    //   extra - after word, also absorb a tail word holding only the length
    //   fin   - finalize after the absorb(s) and emit a result
    //   len   - message length mod 256, used for the extra tail word
    typedef struct packed {
        logic [63:0] word;
        logic        extra;
        logic        fin;
        logic [7:0]  len;
    } t_cmd;

endpackage

[rtl/siphash_discriminator.sv]
`timescale 1ns / 1ps
// Top level of the SipHash-2-4 discriminator.
// Depends on sipd_pkg, sipd_front, sipd_queue and sipd_back.
//
// Takes one message byte per cycle while the command queue has room and
// returns, at the end of each message, the SipHash-2-4 value under a fixed
// key and (hash mod 65535) + 1. The byte packer accepts a beat every cycle
// while the command queue has room; the round engine does one half-round per
// cycle, with separate adders for each half, and keeps up with the byte stream.
// Ending a message takes the engine, from taking the tail command to loading
// the result, through tail absorb, four finalization rounds, hash and fold;
// when the last mark rides on the byte that completes a word, that word is
// absorbed first and a length-only tail word follows. Meanwhile the packer
// keeps taking bytes of the next message until the QUEUE_DEPTH-entry queue
// fills. The result sits in an output register, so the engine can start the
// next message while a result waits to be taken.
module siphash_discriminator #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_present,
    input  logic        i_last_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_discriminator,
    output logic [63:0] o_full_hash
);

    localparam int CMD_W = $bits(sipd_pkg::t_cmd);

    sipd_pkg::t_cmd push_cmd;
    sipd_pkg::t_cmd head_cmd;
    logic           push, pop, full, empty;
    logic [CMD_W-1:0] head_bits;

    // Byte packer
    sipd_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_data_byte    (i_data_byte),
        .i_byte_present (i_byte_present),
        .i_last_item    (i_last_item),
        .o_push         (push),
        .o_cmd          (push_cmd),
        .i_full         (full)
    );

    // Command queue
    sipd_queue #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (head_bits),
        .o_empty (empty)
    );

    assign head_cmd = sipd_pkg::t_cmd'(head_bits);

    // Round engine and result register
    sipd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_empty         (empty),
        .i_cmd           (head_cmd),
        .o_pop           (pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_discriminator (o_discriminator),
        .o_full_hash     (o_full_hash)
    );

endmodule

[rtl/sipd_queue.sv]
`timescale 1ns / 1ps
// Small register FIFO between the byte packer and the round engine.
// Generic in width and depth; no package dependencies.
module sipd_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Pointer and count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!do_push && do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

[rtl/sipd_front.sv]
`timescale 1ns / 1ps
// Byte packer: takes one byte beat per cycle while the queue has room, builds
// little-endian words, issues absorb/finalize commands. Depends on sipd_pkg.
module sipd_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic [7:0]     i_data_byte,
    input  logic           i_byte_present,
    input  logic           i_last_item,
    output logic           o_push,
    output sipd_pkg::t_cmd o_cmd,
    input  logic           i_full
);

    logic [55:0] r_partial, n_partial;
    logic [7:0]  r_count, n_count;
    logic [2:0]  pos;
    logic        accept;
    logic        word_done;
    logic [55:0] ins_partial;

    assign o_in_ready = !i_full;
    assign accept     = i_in_valid && !i_full;
    assign pos        = r_count[2:0];
    assign word_done  = i_byte_present && (pos == 3'd7);

    // Drop the byte into its lane of the partial word
    always_comb begin
        ins_partial = r_partial;
        for (int i = 0; i < 7; i++) begin
            if (pos == 3'(i)) begin
                ins_partial[i*8 +: 8] = i_data_byte;
            end
        end
    end

    // Next state and command
    always_comb begin
        n_partial   = r_partial;
        n_count     = r_count;
        o_push      = 1'b0;
        o_cmd.word  = {i_data_byte, r_partial};
        o_cmd.extra = 1'b0;
        o_cmd.fin   = 1'b0;
        o_cmd.len   = r_count;

        if (i_byte_present) begin
            n_partial = word_done ? '0 : ins_partial;
            n_count   = r_count + 1'b1;
        end
        o_cmd.len = n_count;

        if (i_last_item) begin
            o_cmd.fin = 1'b1;
            if (word_done) begin
                // full word, then a tail word that is only the length
                o_cmd.extra = 1'b1;
            end else begin
                o_cmd.word = {n_count, n_partial};
            end
        end

        if (accept) begin
            o_push = word_done || i_last_item;
            if (i_last_item) begin
                n_partial = '0;
                n_count   = '0;
            end
        end else begin
            n_partial = r_partial;
            n_count   = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial <= '0;
            r_count   <= '0;
        end else begin
            r_partial <= n_partial;
            r_count   <= n_count;
        end
    end

endmodule

[rtl/sipd_back.sv]
`timescale 1ns / 1ps
// Round engine: absorbs queued words, finalizes and holds the result beat,
// with one SipHash half-round per cycle while hashing. Depends on sipd_pkg.
module sipd_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  sipd_pkg::t_cmd i_cmd,
    output logic           o_pop,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic [15:0]    o_discriminator,
    output logic [63:0]    o_full_hash
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ABS,
        S_FIN,
        S_HASH,
        S_OUT
    } t_state;

    localparam logic [2:0] ABS_LAST = 3'd3;
    localparam logic [2:0] FIN_LAST = 3'd7;
    localparam logic [16:0] MOD_VAL = 17'd65535;

    t_state      r_state, n_state;
    logic [63:0] r_a, n_a, r_b, n_b, r_c, n_c, r_d, n_d;
    logic [63:0] r_m, n_m;
    logic        r_extra, n_extra;
    logic        r_fin, n_fin;
    logic [7:0]  r_len, n_len;
    logic [2:0]  r_cnt, n_cnt;
    logic [63:0] r_hash, n_hash;
    logic        r_out_valid, n_out_valid;
    logic [15:0] r_disc, n_disc;
    logic [63:0] r_out_hash, n_out_hash;

    logic [63:0] ha_a, ha_b, ha_c, ha_d;
    logic [63:0] hb_a, hb_b, hb_c, hb_d;
    logic [63:0] h_a, h_b, h_c, h_d;
    logic [63:0] a1, c2, tail;
    logic [17:0] sum18;
    logic [16:0] fold17, red17;
    logic [15:0] disc;

    assign o_out_valid     = r_out_valid;
    assign o_discriminator = r_disc;
    assign o_full_hash     = r_out_hash;
    assign tail            = {r_len, 56'b0};

    // First half-round: a+=b, c+=d
    always_comb begin
        a1   = r_a + r_b;
        ha_b = {r_b[50:0], r_b[63:51]} ^ a1;
        ha_a = {a1[31:0], a1[63:32]};
        ha_c = r_c + r_d;
        ha_d = {r_d[47:0], r_d[63:48]} ^ ha_c;
    end

    // Second half-round: a+=d, c+=b
    always_comb begin
        hb_a = r_a + r_d;
        hb_d = {r_d[42:0], r_d[63:43]} ^ hb_a;
        c2   = r_c + r_b;
        hb_b = {r_b[46:0], r_b[63:47]} ^ c2;
        hb_c = {c2[31:0], c2[63:32]};
    end

    // Even step runs the first half, odd step the second
    assign h_a = r_cnt[0] ? hb_a : ha_a;
    assign h_b = r_cnt[0] ? hb_b : ha_b;
    assign h_c = r_cnt[0] ? hb_c : ha_c;
    assign h_d = r_cnt[0] ? hb_d : ha_d;

    // hash mod 65535: 2^16 is 1 mod 65535, so fold the 16-bit chunks
    always_comb begin
        sum18  = {2'b0, r_hash[15:0]} + {2'b0, r_hash[31:16]}
               + {2'b0, r_hash[47:32]} + {2'b0, r_hash[63:48]};
        fold17 = {1'b0, sum18[15:0]} + {15'b0, sum18[17:16]};
        red17  = (fold17 >= MOD_VAL) ? (fold17 - MOD_VAL) : fold17;
        disc   = red17[15:0] + 16'd1;
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_a         = r_a;
        n_b         = r_b;
        n_c         = r_c;
        n_d         = r_d;
        n_m         = r_m;
        n_extra     = r_extra;
        n_fin       = r_fin;
        n_len       = r_len;
        n_cnt       = r_cnt;
        n_hash      = r_hash;
        n_out_valid = r_out_valid;
        n_disc      = r_disc;
        n_out_hash  = r_out_hash;
        o_pop       = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_d     = r_d ^ i_cmd.word;
                    n_m     = i_cmd.word;
                    n_extra = i_cmd.extra;
                    n_fin   = i_cmd.fin;
                    n_len   = i_cmd.len;
                    n_cnt   = '0;
                    n_state = S_ABS;
                end
            end
            S_ABS: begin
                n_a   = h_a;
                n_b   = h_b;
                n_c   = h_c;
                n_d   = h_d;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == ABS_LAST) begin
                    n_a   = hb_a ^ r_m;
                    n_cnt = '0;
                    if (r_extra) begin
                        // length-only tail word follows a full last word
                        n_extra = 1'b0;
                        n_m     = tail;
                        n_d     = hb_d ^ tail;
                    end else if (r_fin) begin
                        n_c     = hb_c ^ sipd_pkg::FIN_XOR;
                        n_state = S_FIN;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_FIN: begin
                n_a   = h_a;
                n_b   = h_b;
                n_c   = h_c;
                n_d   = h_d;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == FIN_LAST) begin
                    n_state = S_HASH;
                end
            end
            S_HASH: begin
                n_hash  = r_a ^ r_b ^ r_c ^ r_d;
                n_a     = sipd_pkg::LANE_A_RST;
                n_b     = sipd_pkg::LANE_B_RST;
                n_c     = sipd_pkg::LANE_C_RST;
                n_d     = sipd_pkg::LANE_D_RST;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_hash  = r_hash;
                    n_disc      = disc;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_a         <= sipd_pkg::LANE_A_RST;
            r_b         <= sipd_pkg::LANE_B_RST;
            r_c         <= sipd_pkg::LANE_C_RST;
            r_d         <= sipd_pkg::LANE_D_RST;
            r_extra     <= 1'b0;
            r_fin       <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_a         <= n_a;
            r_b         <= n_b;
            r_c         <= n_c;
            r_d         <= n_d;
            r_extra     <= n_extra;
            r_fin       <= n_fin;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
        r_m        <= n_m;
        r_len      <= n_len;
        r_hash     <= n_hash;
        r_disc     <= n_disc;
        r_out_hash <= n_out_hash;
    end

endmodule

[test/siphash_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the SipHash-2-4 discriminator: watches both channels, keeps
// its own copy of the hash lanes and compares each result beat with the oldest
// prediction. Depends on sipd_pkg for the lane reset values and the final xor.
module siphash_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_present,
    input  logic        i_last_item,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [15:0] i_discriminator,
    input  logic [63:0] i_full_hash,
    output int          o_error_count,
    output int          o_pending_results
);

    typedef struct packed {
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        logic [63:0] d;
    } t_sip_lanes;

    typedef struct packed {
        logic [15:0] disc;
        logic [63:0] hash;
    } t_digest;

    localparam t_sip_lanes LANES_INIT = '{sipd_pkg::LANE_A_RST, sipd_pkg::LANE_B_RST,
                                          sipd_pkg::LANE_C_RST, sipd_pkg::LANE_D_RST};

    t_sip_lanes  lanes;
    logic [55:0] tail_bytes;
    logic [7:0]  msg_length;
    t_digest     pending_digests[$];
    t_digest     oldest;
    int          mismatch_total;

    function automatic logic [63:0] rotl64(logic [63:0] x, int n);
        return (x << n) | (x >> (64 - n));
    endfunction

    function automatic t_sip_lanes sip_round(t_sip_lanes s);
        s.a += s.b; s.b = rotl64(s.b, 13); s.b ^= s.a; s.a = rotl64(s.a, 32);
        s.c += s.d; s.d = rotl64(s.d, 16); s.d ^= s.c;
        s.a += s.d; s.d = rotl64(s.d, 21); s.d ^= s.a;
        s.c += s.b; s.b = rotl64(s.b, 17); s.b ^= s.c; s.c = rotl64(s.c, 32);
        return s;
    endfunction

    // Two compression rounds around one 64-bit message word
    function automatic t_sip_lanes absorb_word(t_sip_lanes s, logic [63:0] w);
        s.d ^= w;
        s = sip_round(s);
        s = sip_round(s);
        s.a ^= w;
        return s;
    endfunction

    // Advance the predicted hash state by one input beat
    task automatic hash_beat(input logic [7:0] data, input logic present, input logic last);
        t_digest     fresh;
        logic [63:0] hash;
        if (present) begin
            if (msg_length[2:0] == 3'd7) begin
                lanes      = absorb_word(lanes, {data, tail_bytes});
                tail_bytes = '0;
            end else begin
                tail_bytes[msg_length[2:0] * 8 +: 8] = data;
            end
            msg_length = msg_length + 8'd1;
        end
        if (last) begin
            // tail word carries the length in its top byte, then finalize
            lanes    = absorb_word(lanes, {msg_length, tail_bytes});
            lanes.c ^= sipd_pkg::FIN_XOR;
            repeat (4) lanes = sip_round(lanes);
            hash       = lanes.a ^ lanes.b ^ lanes.c ^ lanes.d;
            fresh.hash = hash;
            fresh.disc = 16'((hash % 64'd65535) + 64'd1);
            pending_digests.push_back(fresh);
            lanes      = LANES_INIT;
            tail_bytes = '0;
            msg_length = '0;
        end
    endtask

    // Predict on every input beat, compare on every result beat
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            lanes      = LANES_INIT;
            tail_bytes = '0;
            msg_length = '0;
            pending_digests.delete();
            mismatch_total = 0;
        end else begin
            if (i_in_valid && i_in_ready)
                hash_beat(i_data_byte, i_byte_present, i_last_item);
            if (i_out_valid && i_out_ready) begin
                if (pending_digests.size() == 0) begin
                    $error("unexpected result beat: discriminator %0d, full_hash %h",
                           i_discriminator, i_full_hash);
                    mismatch_total++;
                end else begin
                    oldest = pending_digests.pop_front();
                    if (i_discriminator !== oldest.disc) begin
                        $error("discriminator: expected %0d, actual %0d",
                               oldest.disc, i_discriminator);
                        mismatch_total++;
                    end
                    if (i_full_hash !== oldest.hash) begin
                        $error("full_hash: expected %h, actual %h", oldest.hash, i_full_hash);
                        mismatch_total++;
                    end
                end
            end
        end
        o_error_count     <= mismatch_total;
        o_pending_results <= pending_digests.size();
    end

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// Top of the SipHash-2-4 discriminator test: drives byte messages with bursty
// gaps and a stalling receiver, and reports the verdict.
// Depends on sipd_pkg, siphash_discriminator and siphash_checker.
module testbench;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_MOSTLY,
        READY_RARELY,
        READY_PERIODIC
    } t_stall_mode;

    localparam int IDLE_LIMIT  = 2000;
    localparam int DRAIN_WAIT  = 40;
    localparam int ITEM_TARGET = 500;
    localparam int MSG_TARGET  = 30;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic [7:0]  data_byte  = 8'h00;
    logic        byte_present = 1'b0;
    logic        last_item  = 1'b0;
    logic        out_ready  = 1'b0;
    logic        in_ready;
    logic        out_valid;
    logic [15:0] discriminator;
    logic [63:0] full_hash;
    int          error_count;
    int          pending_results;

    t_stall_mode stall_mode = READY_ALWAYS;
    int          mode_left  = 0;
    int          burst_left = 0;
    int          item_total = 0;
    int          msg_total  = 0;
    int          idle_cycles = 0;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    siphash_discriminator dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_data_byte     (data_byte),
        .i_byte_present  (byte_present),
        .i_last_item     (last_item),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_discriminator (discriminator),
        .o_full_hash     (full_hash)
    );

    siphash_checker u_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .i_in_ready        (in_ready),
        .i_data_byte       (data_byte),
        .i_byte_present    (byte_present),
        .i_last_item       (last_item),
        .i_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .i_discriminator   (discriminator),
        .i_full_hash       (full_hash),
        .o_error_count     (error_count),
        .o_pending_results (pending_results)
    );

    // Receiver backpressure, switching between patterns every so often
    always @(posedge clk) begin
        if (mode_left == 0) begin
            stall_mode <= t_stall_mode'($urandom_range(0, 3));
            mode_left  <= $urandom_range(30, 200);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (stall_mode)
            READY_ALWAYS:   out_ready <= 1'b1;
            READY_MOSTLY:   out_ready <= ($urandom_range(0, 3) != 0);
            READY_RARELY:   out_ready <= ($urandom_range(0, 3) == 0);
            READY_PERIODIC: out_ready <= (mode_left[3:0] < 4'd5);
            default:        out_ready <= 1'b1;
        endcase
    end

    // Watchdog: any beat on either channel restarts the count
    initial begin
        while (!rst_n) @(posedge clk);
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // Present one beat, hold it until taken, then maybe end the burst
    task automatic send_beat(input logic [7:0] d, input logic p, input logic l);
        in_valid     <= 1'b1;
        data_byte    <= d;
        byte_present <= p;
        last_item    <= l;
        do @(posedge clk); while (!in_ready);
        if (p || l)
            item_total++;
        if (burst_left == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(0, 12);
        end else begin
            burst_left--;
        end
    endtask

    // Random-content message; the last mark rides on the final byte or on an
    // empty closing beat. Occasional idle beats land before some of the bytes.
    task automatic send_message(input int len, input bit last_on_byte, input int idle_pct);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 99) < idle_pct)
                send_beat(8'($urandom), 1'b0, 1'b0);
            send_beat(8'($urandom), 1'b1, last_on_byte && (i == len - 1));
        end
        if (!last_on_byte || len == 0)
            send_beat(8'($urandom), 1'b0, 1'b1);
        msg_total++;
    endtask

    // Hold off the sender until every predicted result has been taken
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0) @(posedge clk);
    endtask

    initial begin
        int len;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty message, single extreme bytes, word boundaries
        send_beat(8'h00, 1'b0, 1'b1);
        send_beat(8'h00, 1'b1, 1'b1);
        send_beat(8'hff, 1'b1, 1'b1);
        send_beat(8'hff, 1'b1, 1'b0);
        send_beat(8'h00, 1'b1, 1'b0);
        send_beat(8'h5a, 1'b0, 1'b0);
        send_beat(8'ha5, 1'b1, 1'b0);
        send_message(4, 1'b0, 0);
        send_message(8, 1'b1, 0);
        send_message(8, 1'b0, 0);
        wait_drained();

        // Random: mostly short messages, one that wraps the length byte
        while (item_total < ITEM_TARGET || msg_total < MSG_TARGET) begin
            if (msg_total == 12)
                len = $urandom_range(256, 270);
            else if ($urandom_range(0, 3) != 0)
                len = $urandom_range(0, 9);
            else
                len = $urandom_range(10, 24);
            send_message(len, 1'($urandom), 5);
            if (msg_total == 25)
                wait_drained();
        end

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[siphash_discriminator.f]
rtl/sipd_pkg.sv
rtl/sipd_queue.sv
rtl/sipd_front.sv
rtl/sipd_back.sv
rtl/siphash_discriminator.sv
test/siphash_checker.sv
test/testbench.sv
